// ----- sv/kwl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_pkg
// Shared types, constants and character-class helpers for the keyword lexer.
// ----------------------------------------------------------------------------
package kwl_pkg;

    localparam int MAX_WORD_CHARS_DEF = 8;
    localparam int NUM_KEYWORDS_DEF   = 4;
    localparam int TEXT_W             = 64;
    localparam int LEN_W              = 4;
    localparam int CHAR_W             = 8;
    localparam int CFG_IDX_W          = 2;
    localparam int FIFO_DEPTH         = 4;
    localparam int FIFO_PTR_W         = 2;
    localparam int FIFO_CNT_W         = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_3 = 2'd3;

    typedef enum logic [1:0] {
        KIND_KEYWORD = 2'd0,
        KIND_WORD    = 2'd1,
        KIND_SYMBOL  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TEXT_W-1:0]  text;
        logic [LEN_W-1:0]   length;
        logic               truncated;
        logic               last;
    } t_token;

    // Up to two tokens produced by one character
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic [TEXT_W-1:0] kw_reset(input logic [CFG_IDX_W-1:0] idx);
        logic [TEXT_W-1:0] v;
        case (idx)
            CFG_KEYWORD_0: v = 64'd1684631414;            // "void"
            CFG_KEYWORD_1: v = 64'd7957695015192261990;   // "function"
            CFG_KEYWORD_2: v = 64'd1953853283;            // "cout"
            CFG_KEYWORD_3: v = 64'd121437875889522;       // "return"
            default:       v = '0;
        endcase
        return v;
    endfunction

    function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
        return (c inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]});
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c inside {8'd32, [8'd9:8'd13]});
    endfunction

endpackage

// ----- sv/kwl_kwbank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_kwbank
// Keyword registers with their write port and a parallel equality compare.
// ----------------------------------------------------------------------------
module kwl_kwbank #(
    parameter int NUM_KEYWORDS = kwl_pkg::NUM_KEYWORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kwl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kwl_pkg::TEXT_W-1:0]     i_cfg_data,
    input  logic [kwl_pkg::TEXT_W-1:0]     i_word,
    output logic                           o_hit
);
    import kwl_pkg::*;

    logic [TEXT_W-1:0] r_kw [NUM_KEYWORDS];

    // Hold one register per enabled keyword; drop writes to the others
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_KEYWORDS; i++) begin
            if (!i_rst_n) begin
                r_kw[i] <= kw_reset(CFG_IDX_W'(i));
            end else if (i_cfg_we && (i_cfg_index == CFG_IDX_W'(i))) begin
                r_kw[i] <= i_cfg_data;
            end
        end
    end

    always_comb begin
        o_hit = 1'b0;
        for (int i = 0; i < NUM_KEYWORDS; i++) begin
            if (r_kw[i] == i_word) begin
                o_hit = 1'b1;
            end
        end
    end

endmodule

// ----- sv/kwl_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_scan
// Word gathering state and token formation for one character per cycle while i_fire is high.
// ----------------------------------------------------------------------------
module kwl_scan #(
    parameter int MAX_WORD_CHARS = kwl_pkg::MAX_WORD_CHARS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [kwl_pkg::CHAR_W-1:0]   i_character,
    input  logic                         i_line_end,
    input  logic                         i_hit,
    output logic [kwl_pkg::TEXT_W-1:0]   o_word,
    output kwl_pkg::t_push               o_push
);
    import kwl_pkg::*;

    localparam int CW    = $clog2(MAX_WORD_CHARS + 1);
    localparam int BUF_W = CHAR_W * MAX_WORD_CHARS;

    logic             r_in_word, n_in_word;
    logic [BUF_W-1:0] r_buf, n_buf;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_ovf, n_ovf;

    logic             w_word_char;
    logic             w_blank;
    logic [BUF_W-1:0] upd_buf;
    logic [CW-1:0]    upd_cnt;
    logic             upd_ovf;
    logic [BUF_W-1:0] emit_buf;
    logic [CW-1:0]    emit_cnt;
    logic             emit_ovf;
    logic             emit_word;
    logic             emit_sym;
    t_token           word_tok;
    t_token           sym_tok;

    always_comb begin
        w_word_char = is_word_char(i_character);
        w_blank     = is_blank(i_character);

        // Append the character, or mark overflow once the buffer is full
        upd_buf = r_buf;
        upd_cnt = r_cnt;
        upd_ovf = r_ovf;
        if (r_cnt < CW'(MAX_WORD_CHARS)) begin
            for (int i = 0; i < MAX_WORD_CHARS; i++) begin
                if (r_cnt == CW'(i)) begin
                    upd_buf[i*CHAR_W +: CHAR_W] = i_character;
                end
            end
            upd_cnt = r_cnt + 1'b1;
        end else begin
            upd_ovf = 1'b1;
        end

        emit_word = w_word_char ? i_line_end : r_in_word;
        emit_sym  = !w_word_char && !w_blank;
        emit_buf  = w_word_char ? upd_buf : r_buf;
        emit_cnt  = w_word_char ? upd_cnt : r_cnt;
        emit_ovf  = w_word_char ? upd_ovf : r_ovf;

        o_word = TEXT_W'(emit_buf);

        word_tok.kind      = (i_hit && !emit_ovf) ? KIND_KEYWORD : KIND_WORD;
        word_tok.text      = TEXT_W'(emit_buf);
        word_tok.length    = LEN_W'(emit_cnt);
        word_tok.truncated = emit_ovf;
        word_tok.last      = !emit_sym;

        sym_tok.kind       = KIND_SYMBOL;
        sym_tok.text       = TEXT_W'(i_character);
        sym_tok.length     = LEN_W'(1);
        sym_tok.truncated  = 1'b0;
        sym_tok.last       = 1'b1;

        o_push.tok0  = emit_word ? word_tok : sym_tok;
        o_push.tok1  = sym_tok;
        o_push.count = i_fire ? ({1'b0, emit_word} + {1'b0, emit_sym}) : 2'd0;

        n_in_word = r_in_word;
        n_buf     = r_buf;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        if (i_fire) begin
            if (w_word_char && !i_line_end) begin
                n_in_word = 1'b1;
                n_buf     = upd_buf;
                n_cnt     = upd_cnt;
                n_ovf     = upd_ovf;
            end else if (!w_word_char || i_line_end) begin
                // Non-word character or line end: clear the word state
                n_in_word = (w_word_char && !i_line_end);
                n_buf     = '0;
                n_cnt     = '0;
                n_ovf     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word <= 1'b0;
            r_buf     <= '0;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_in_word <= n_in_word;
            r_buf     <= n_buf;
            r_cnt     <= n_cnt;
            r_ovf     <= n_ovf;
        end
    end

endmodule

// ----- sv/kwl_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_fifo
// Result queue: takes up to two tokens per cycle, presents one per cycle while the reader pops.
// ----------------------------------------------------------------------------
module kwl_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kwl_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_space2,
    output logic             o_valid,
    output kwl_pkg::t_token  o_head
);
    import kwl_pkg::*;

    t_token                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, n_wr;
    logic [FIFO_PTR_W-1:0] r_rd, n_rd;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic [FIFO_PTR_W-1:0] wr_next;
    logic                  pop_ok;

    always_comb begin
        wr_next  = FIFO_PTR_W'(r_wr + 1'b1);
        pop_ok   = i_pop && (r_count != '0);
        n_wr     = FIFO_PTR_W'(r_wr + i_push.count);
        n_rd     = pop_ok ? FIFO_PTR_W'(r_rd + 1'b1) : r_rd;
        n_count  = r_count + FIFO_CNT_W'(i_push.count) - FIFO_CNT_W'(pop_ok);
        o_space2 = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
        o_valid  = (r_count != '0);
        o_head   = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- sv/keyword_lexer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_lexer_core
// Character-stream lexer: gathers words, flags configured keywords, reports
// symbols and skips white space.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction waits in the input register until the queue
//   has room for two tokens, is then scanned, and its tokens enter the queue.
// Throughput: one character per cycle while the output is ready and each
//   character yields at most one token; a character that ends a word and is a
//   symbol yields two, and the single-token output port then sets the pace.
// Reset: synchronous, active low; clears the word state and the result queue
//   and loads the four default keywords.
// ----------------------------------------------------------------------------
module keyword_lexer_core #(
    parameter int MAX_WORD_CHARS = kwl_pkg::MAX_WORD_CHARS_DEF,
    parameter int NUM_KEYWORDS   = kwl_pkg::NUM_KEYWORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [kwl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kwl_pkg::TEXT_W-1:0]    i_cfg_data,
    // character input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [kwl_pkg::CHAR_W-1:0]    i_character,
    input  logic                          i_line_end,
    // token output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_token_kind,
    output logic [kwl_pkg::TEXT_W-1:0]    o_token_text,
    output logic [kwl_pkg::LEN_W-1:0]     o_token_length,
    output logic                          o_truncated,
    output logic                          o_last_of_run
);
    import kwl_pkg::*;

    // Input register: holds one accepted transaction until it is scanned
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_eol;

    logic              fire;
    logic              space2;
    logic [TEXT_W-1:0] word;
    logic              hit;
    t_push             push;
    t_token            head;

    // Scan only when the queue can take the worst case of two tokens, so a
    // character never has to be split across cycles.
    assign fire       = r_in_valid && space2;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload needs no reset; load on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char <= i_character;
            r_in_eol  <= i_line_end;
        end
    end

    kwl_kwbank #(
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_kwbank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_word      (word),
        .o_hit       (hit)
    );

    // Word state update and token build; the word under compare goes out to
    // the keyword bank and the hit comes back in the same cycle.
    kwl_scan #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_character (r_in_char),
        .i_line_end  (r_in_eol),
        .i_hit       (hit),
        .o_word      (word),
        .o_push      (push)
    );

    // Result queue decouples token bursts from the output handshake
    kwl_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (i_out_ready),
        .o_space2 (space2),
        .o_valid  (o_out_valid),
        .o_head   (head)
    );

    assign o_token_kind   = head.kind;
    assign o_token_text   = head.text;
    assign o_token_length = head.length;
    assign o_truncated    = head.truncated;
    assign o_last_of_run  = head.last;

endmodule

// ----- sv/kwl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_checker
// Port-level checks on the token output of the keyword lexer.
// ----------------------------------------------------------------------------
module kwl_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  logic [1:0]                 o_token_kind,
    input  logic [kwl_pkg::TEXT_W-1:0] o_token_text,
    input  logic [kwl_pkg::LEN_W-1:0]  o_token_length,
    input  logic                       o_truncated,
    input  logic                       o_last_of_run
);
    import kwl_pkg::*;

    // A stalled token holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_token_text) && $stable(o_token_kind))
        else $error("token changed while stalled");

    // A symbol is one character and always closes its run
    a_symbol_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == KIND_SYMBOL) |->
            (o_token_length == LEN_W'(1)) && !o_truncated && o_last_of_run &&
            (o_token_text[TEXT_W-1:CHAR_W] == '0))
        else $error("malformed symbol token");

    // A truncated word never reports as a keyword
    a_keyword_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == KIND_KEYWORD) |-> !o_truncated)
        else $error("truncated word matched a keyword");

    // Every token carries one to eight characters
    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_token_length != '0) && (o_token_length <= LEN_W'(8)))
        else $error("token length out of range");

endmodule

bind keyword_lexer_core kwl_checker u_kwl_checker (.*);

// ----- sim/keyword_lexer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_lexer_checker
// Watches the character, token and register ports of the keyword lexer,
// predicts the token stream and compares each token field by field.
// ----------------------------------------------------------------------------
module keyword_lexer_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kwl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kwl_pkg::TEXT_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [kwl_pkg::CHAR_W-1:0]    i_character,
    input  logic                          i_line_end,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_token_kind,
    input  logic [kwl_pkg::TEXT_W-1:0]    i_token_text,
    input  logic [kwl_pkg::LEN_W-1:0]     i_token_length,
    input  logic                          i_truncated,
    input  logic                          i_last_of_run,
    output int                            o_errors,
    output int                            o_pending
);
    import kwl_pkg::*;

    localparam int PRINT_CAP = 100;

    logic [TEXT_W-1:0] keyword_copy [NUM_KEYWORDS_DEF];
    logic              in_word;
    logic [TEXT_W-1:0] word_text;
    int                word_len;
    logic              word_over;
    t_token            expected_tokens [$];
    int                error_count = 0;
    int                token_index = 0;

    assign o_errors  = error_count;
    assign o_pending = expected_tokens.size();

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void clear_word();
        in_word   = 1'b0;
        word_text = '0;
        word_len  = 0;
        word_over = 1'b0;
    endfunction

    // An overlong word never matches; otherwise the padded buffer must equal
    // a whole register.
    function automatic t_token close_word();
        t_token tok;
        logic   hit;
        hit = 1'b0;
        if (!word_over) begin
            foreach (keyword_copy[k]) begin
                if (keyword_copy[k] == word_text) hit = 1'b1;
            end
        end
        tok.kind      = hit ? KIND_KEYWORD : KIND_WORD;
        tok.text      = word_text;
        tok.length    = LEN_W'(word_len);
        tok.truncated = word_over;
        tok.last      = 1'b0;
        clear_word();
        return tok;
    endfunction

    function automatic void predict_tokens(input logic [CHAR_W-1:0] ch, input logic eol);
        t_token run [$];
        t_token sym;
        if (is_alnum(ch)) begin
            in_word = 1'b1;
            if (word_len < MAX_WORD_CHARS_DEF) begin
                word_text[8*word_len +: 8] = ch;
                word_len++;
            end else begin
                word_over = 1'b1;
            end
            if (eol) run.push_back(close_word());
        end else begin
            if (in_word) run.push_back(close_word());
            if (!is_space(ch)) begin
                sym.kind      = KIND_SYMBOL;
                sym.text      = '0;
                sym.text[7:0] = ch;
                sym.length    = LEN_W'(1);
                sym.truncated = 1'b0;
                sym.last      = 1'b0;
                run.push_back(sym);
            end
        end
        if (eol) clear_word();
        if (run.size() > 0) run[run.size()-1].last = 1'b1;
        foreach (run[k]) expected_tokens.push_back(run[k]);
    endfunction

    always @(posedge i_clk) begin : watch
        t_token want;
        if (!i_rst_n) begin
            keyword_copy[CFG_KEYWORD_0] = 64'h0000_0000_6469_6F76;
            keyword_copy[CFG_KEYWORD_1] = 64'h6E6F_6974_636E_7566;
            keyword_copy[CFG_KEYWORD_2] = 64'h0000_0000_7475_6F63;
            keyword_copy[CFG_KEYWORD_3] = 64'h0000_6E72_7574_6572;
            clear_word();
            expected_tokens.delete();
        end else begin
            // compare before pushing: a token can never come from this edge's input
            if (i_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_error($sformatf("token %0d arrived with none expected, text %0h",
                                           token_index, i_token_text));
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_token_kind !== want.kind)
                        report_error($sformatf("token %0d kind %0d, expected %0d",
                                               token_index, i_token_kind, want.kind));
                    if (i_token_text !== want.text)
                        report_error($sformatf("token %0d text %0h, expected %0h",
                                               token_index, i_token_text, want.text));
                    if (i_token_length !== want.length)
                        report_error($sformatf("token %0d length %0d, expected %0d",
                                               token_index, i_token_length, want.length));
                    if (i_truncated !== want.truncated)
                        report_error($sformatf("token %0d truncated %0b, expected %0b",
                                               token_index, i_truncated, want.truncated));
                    if (i_last_of_run !== want.last)
                        report_error($sformatf("token %0d last_of_run %0b, expected %0b",
                                               token_index, i_last_of_run, want.last));
                end
                token_index++;
            end
            if (i_cfg_we) keyword_copy[i_cfg_index] = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_tokens(i_character, i_line_end);
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives character streams into the keyword lexer across several keyword
// settings and idle patterns; a checker beside the block predicts every token.
// ----------------------------------------------------------------------------
module tb;
    import kwl_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 300;      // long receiver stall for back-pressure
    localparam int SETTLE_CYCLES = 8;        // covers the scan and output stages

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_KEYWORD_0;
    logic [TEXT_W-1:0]    i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [CHAR_W-1:0]    i_character = '0;
    logic                 i_line_end  = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_token_kind;
    logic [TEXT_W-1:0]    o_token_text;
    logic [LEN_W-1:0]     o_token_length;
    logic                 o_truncated;
    logic                 o_last_of_run;

    int    error_count;
    int    pending_tokens;
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    logic  hold_req    = 1'b0;
    int    hold_left   = 0;
    int    cycle_count = 0;
    int    chars_sent  = 0;
    string keyword_text [4];

    keyword_lexer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_character    (i_character),
        .i_line_end     (i_line_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_token_text   (o_token_text),
        .o_token_length (o_token_length),
        .o_truncated    (o_truncated),
        .o_last_of_run  (o_last_of_run)
    );

    keyword_lexer_checker token_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_character    (i_character),
        .i_line_end     (i_line_end),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_token_kind   (o_token_kind),
        .i_token_text   (o_token_text),
        .i_token_length (o_token_length),
        .i_truncated    (o_truncated),
        .i_last_of_run  (o_last_of_run),
        .o_errors       (error_count),
        .o_pending      (pending_tokens)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: end the run if the token stream hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Token receiver. A hold request freezes ready for HOLD_CYCLES, counted
    // here, while the sender keeps offering characters.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic is_alnum_char(input logic [CHAR_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_white(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [CHAR_W-1:0] random_alnum();
        int n;
        n = $urandom_range(61);
        if (n < 10) return CHAR_W'("0" + n);
        if (n < 36) return CHAR_W'("A" + n - 10);
        return CHAR_W'("a" + n - 36);
    endfunction

    function automatic string random_word(input int len);
        string w;
        w = "";
        repeat (len) w = $sformatf("%s%c", w, random_alnum());
        return w;
    endfunction

    // First character lands in the low byte; anything past eight is dropped.
    function automatic logic [TEXT_W-1:0] pack_word(input string s);
        logic [TEXT_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < MAX_WORD_CHARS_DEF; i++) v[8*i +: 8] = s[i];
        return v;
    endfunction

    // Offer one character, hold it until the transaction completes, then
    // maybe idle. Valid is only lowered when a gap follows, so it never gets
    // two assignments in one step.
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eol);
        i_in_valid  <= 1'b1;
        i_character <= ch;
        i_line_end  <= eol;
        do @(posedge i_clk); while (!o_in_ready);
        if (!is_white(ch)) chars_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic send_text(input string s, input logic eol_last);
        for (int i = 0; i < s.len(); i++) send_char(s[i], eol_last && (i == s.len() - 1));
    endtask

    // Drop valid and wait until every predicted token has been taken, plus
    // SETTLE_CYCLES for a token-less character that may still be in the pipe.
    task automatic drain_tokens();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_tokens != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_keywords(input logic [TEXT_W-1:0] kw0, input logic [TEXT_W-1:0] kw1,
                                 input logic [TEXT_W-1:0] kw2, input logic [TEXT_W-1:0] kw3);
        logic [TEXT_W-1:0] vals [4];
        vals = '{kw0, kw1, kw2, kw3};
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_KEYWORD_0;
        i_cfg_data  <= kw0;
        @(posedge i_clk);
        i_cfg_index <= CFG_KEYWORD_1;
        i_cfg_data  <= kw1;
        @(posedge i_clk);
        i_cfg_index <= CFG_KEYWORD_2;
        i_cfg_data  <= kw2;
        @(posedge i_clk);
        i_cfg_index <= CFG_KEYWORD_3;
        i_cfg_data  <= kw3;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        // keep the keyword spellings around to aim random words at them
        foreach (vals[k]) begin
            keyword_text[k] = "";
            for (int b = 0; b < MAX_WORD_CHARS_DEF; b++) begin
                if (vals[k][8*b +: 8] == 8'h00) break;
                keyword_text[k] = $sformatf("%s%c", keyword_text[k], vals[k][8*b +: 8]);
            end
        end
    endtask

    // Mostly words with a separator, aimed at the keywords about half the
    // time (exact, one char longer, one char shorter); the rest is raw bytes.
    task automatic run_text(input int n_items);
        int                target;
        int                pick;
        string             w;
        logic [CHAR_W-1:0] sep;
        target = chars_sent + n_items;
        while (chars_sent < target) begin
            if ($urandom_range(99) < 75) begin
                pick = $urandom_range(3);
                w    = keyword_text[$urandom_range(3)];
                if (w.len() == 0 || $urandom_range(99) < 45) begin
                    w = random_word(($urandom_range(99) < 85) ? $urandom_range(1, 8)
                                                              : $urandom_range(9, 14));
                end else if (pick == 2) begin
                    w = $sformatf("%s%c", w, random_alnum());
                end else if (pick == 3 && w.len() > 1) begin
                    w = w.substr(0, w.len() - 2);
                end
                if ($urandom_range(99) < 20) begin
                    send_text(w, 1'b1);
                end else begin
                    send_text(w, 1'b0);
                    case ($urandom_range(2))
                        0: begin
                            pick = $urandom_range(6);
                            sep  = (pick < 5) ? CHAR_W'(9 + pick) : 8'h20;
                        end
                        1: begin
                            do sep = CHAR_W'($urandom_range(33, 126));
                            while (is_alnum_char(sep));
                        end
                        default: sep = CHAR_W'($urandom_range(255));
                    endcase
                    send_char(sep, $urandom_range(99) < 15);
                end
            end else begin
                send_char(CHAR_W'($urandom_range(255)), $urandom_range(9) == 0);
            end
        end
    endtask

    initial begin
        keyword_text = '{"void", "function", "cout", "return"};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles 32%, receiver 77%; reset keywords first.
        tx_idle_pct = 32;
        rx_idle_pct = 77;
        send_text("void(", 1'b0);           // keyword then symbol from one character
        send_text("cout", 1'b1);            // keyword closed by the line end
        send_text("functions.", 1'b0);      // truncated to a keyword's text, no match
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);             // high byte as a symbol at a line end
        send_char(8'h80, 1'b0);
        send_char(8'h20, 1'b1);             // blank at a line end, no token
        send_char("9", 1'b1);               // single digit word at a line end
        drain_tokens();

        // Extremes: an empty and an all-ones register never match, one-char
        // and full eight-char keywords do.
        load_keywords('0, '1, pack_word("a"), pack_word("ZZZZZZZZ"));
        run_text(250);
        drain_tokens();

        // Swap the idle pattern and use random keywords, one full length.
        tx_idle_pct = 77;
        rx_idle_pct = 32;
        load_keywords(pack_word(random_word($urandom_range(1, 8))),
                      pack_word(random_word(MAX_WORD_CHARS_DEF)),
                      pack_word(random_word($urandom_range(1, 8))),
                      pack_word(random_word($urandom_range(1, 8))));
        run_text(230);
        drain_tokens();

        // No idling. Third register has a zero byte inside, so it cannot match.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_keywords(pack_word("void"), pack_word("function"),
                      64'h0000_0000_6300_6261, pack_word("return"));
        run_text(60);
        // Stall the receiver while characters keep coming, so the block fills
        // and drops its ready; then pause the sender until all tokens are out.
        hold_req = 1'b1;
        run_text(60);
        drain_tokens();
        run_text(150);
        drain_tokens();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
